>>> rtl/efm_channel_encoder_defines.svh
// assertion macros for the efm channel encoder
// needs clk and rst_n in the scope of use
`ifndef EFM_CHANNEL_ENCODER_DEFINES_SVH
`define EFM_CHANNEL_ENCODER_DEFINES_SVH

// same-cycle implication
`define EFM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efm assertion failed");

// next-cycle implication
`define EFM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efm assertion failed");

`endif

>>> rtl/efm_pkg.sv
// shared types and constants of the efm channel encoder
// no dependencies
package efm_pkg;

    localparam logic [23:0] SYNC_PATTERN = 24'h801002;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW = 2;
    localparam int unsigned QUEUE_W = 64;
    localparam logic [6:0] RUN_WINDOW = 7'd12;

    typedef enum logic [1:0] {
        SEG_SYNC_WORD,
        SEG_WORD_WORD,
        SEG_WORD_SYNC
    } seg_kind_t;

    typedef struct packed {
        seg_kind_t   kind;
        logic [13:0] word_a;
        logic [13:0] word_b;
        logic        first_seg;
        logic        last_seg;
        logic        frame_end;
    } seg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHECK,
        BK_WORD,
        BK_MERGE,
        BK_RUN
    } bk_state_t;

    typedef struct packed {
        logic push;
        logic full;
    } fifo_wr_t;

    localparam logic [13:0] EFM_TABLE [256] = '{
        14'h1220,14'h2100,14'h2420,14'h2220,14'h1100,14'h0110,14'h0420,14'h0900,
        14'h1240,14'h2040,14'h2440,14'h2240,14'h1040,14'h0040,14'h0440,14'h0840,
        14'h2020,14'h2080,14'h2480,14'h0820,14'h1080,14'h0080,14'h0480,14'h0880,
        14'h1210,14'h2010,14'h2410,14'h2210,14'h1010,14'h0210,14'h0410,14'h0810,
        14'h0020,14'h2108,14'h0220,14'h0920,14'h1108,14'h0108,14'h1020,14'h0908,
        14'h1248,14'h2048,14'h2448,14'h2248,14'h1048,14'h0048,14'h0448,14'h0848,
        14'h0100,14'h2088,14'h2488,14'h2110,14'h1088,14'h0088,14'h0488,14'h0888,
        14'h1208,14'h2008,14'h2408,14'h2208,14'h1008,14'h0208,14'h0408,14'h0808,
        14'h1224,14'h2124,14'h2424,14'h2224,14'h1124,14'h0024,14'h0424,14'h0924,
        14'h1244,14'h2044,14'h2444,14'h2244,14'h1044,14'h0044,14'h0444,14'h0844,
        14'h2024,14'h2084,14'h2484,14'h0824,14'h1084,14'h0084,14'h0484,14'h0884,
        14'h1204,14'h2004,14'h2404,14'h2204,14'h1004,14'h0204,14'h0404,14'h0804,
        14'h1222,14'h2122,14'h2422,14'h2222,14'h1122,14'h0022,14'h1024,14'h0922,
        14'h1242,14'h2042,14'h2442,14'h2242,14'h1042,14'h0042,14'h0442,14'h0842,
        14'h2022,14'h2082,14'h2482,14'h0822,14'h1082,14'h0082,14'h0482,14'h0882,
        14'h1202,14'h0248,14'h2402,14'h2202,14'h1002,14'h0202,14'h0402,14'h0802,
        14'h1221,14'h2121,14'h2421,14'h2221,14'h1121,14'h0021,14'h0421,14'h0921,
        14'h1241,14'h2041,14'h2441,14'h2241,14'h1041,14'h0041,14'h0441,14'h0841,
        14'h2021,14'h2081,14'h2481,14'h0821,14'h1081,14'h0081,14'h0481,14'h0881,
        14'h1201,14'h2090,14'h2401,14'h2201,14'h1090,14'h0201,14'h0401,14'h0890,
        14'h0221,14'h2109,14'h1110,14'h0121,14'h1109,14'h0109,14'h1021,14'h0909,
        14'h1249,14'h2049,14'h2449,14'h2249,14'h1049,14'h0049,14'h0449,14'h0849,
        14'h0120,14'h2089,14'h2489,14'h0910,14'h1089,14'h0089,14'h0489,14'h0889,
        14'h1209,14'h2009,14'h2409,14'h2209,14'h1009,14'h0209,14'h0409,14'h0809,
        14'h1120,14'h2111,14'h2490,14'h0224,14'h1111,14'h0111,14'h0490,14'h0911,
        14'h0241,14'h2101,14'h0244,14'h0240,14'h1101,14'h0101,14'h0090,14'h0901,
        14'h0124,14'h2091,14'h2491,14'h2120,14'h1091,14'h0091,14'h0491,14'h0891,
        14'h1211,14'h2011,14'h2411,14'h2211,14'h1011,14'h0211,14'h0411,14'h0811,
        14'h1102,14'h0102,14'h2112,14'h0902,14'h1112,14'h0112,14'h1022,14'h0912,
        14'h2102,14'h2104,14'h0249,14'h0242,14'h1104,14'h0104,14'h0422,14'h0904,
        14'h0122,14'h2092,14'h2492,14'h0222,14'h1092,14'h0092,14'h0492,14'h0892,
        14'h1212,14'h2012,14'h2412,14'h2212,14'h1012,14'h0212,14'h0412,14'h0812
    };

endpackage

>>> rtl/efm_if.sv
// valid/ready channels of the efm channel encoder
// no dependencies
interface efm_byte_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface efm_run_if ();
    logic       valid;
    logic       ready;
    logic [3:0] run_length;
    logic       last_of_item;
    logic       frame_done;
    logic       coding_error;

    modport source (output valid, output run_length, output last_of_item,
                    output frame_done, output coding_error, input ready);
    modport sink (input valid, input run_length, input last_of_item,
                  input frame_done, input coding_error, output ready);
endinterface

>>> rtl/efm_channel_encoder.sv
// a byte is taken only once the segments of the byte before are in the segment queue;
// the back end sequencer takes each merge segment (one a byte, two at frame end) through
// its check, word and merge states and emits the byte's run lengths after its last one
// reset: asynchronous active low, clears frame position, running sum and bit queue
// top level of the efm channel encoder; depends on efm_pkg, efm_if, efm_front,
// efm_fifo and efm_back
module efm_channel_encoder #(
    parameter int BYTES_PER_FRAME = 33
) (
    input  logic       clk,
    input  logic       rst_n,
    efm_byte_if.sink   byte_in,
    efm_run_if.source  run_out
);
    import efm_pkg::*;

    fifo_wr_t wr;
    seg_t     front_seg, fifo_seg;
    logic     fifo_full, fifo_empty, pop;

    efm_front #(.BYTES_PER_FRAME(BYTES_PER_FRAME)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_in.valid),
        .in_ready  (byte_in.ready),
        .in_byte   (byte_in.data_byte),
        .wr        (wr),
        .fifo_full (fifo_full),
        .seg_out   (front_seg)
    );

    efm_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wr_data (front_seg),
        .full    (fifo_full),
        .empty   (fifo_empty),
        .pop     (pop),
        .rd_data (fifo_seg)
    );

    efm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .seg        (fifo_seg),
        .out_valid  (run_out.valid),
        .out_ready  (run_out.ready),
        .out_run    (run_out.run_length),
        .out_last   (run_out.last_of_item),
        .out_frame  (run_out.frame_done),
        .out_err    (run_out.coding_error)
    );

endmodule

>>> rtl/efm_front.sv
// front end: takes frame bytes, tracks frame position, emits segments
// depends on efm_pkg
module efm_front #(
    parameter int BYTES_PER_FRAME = 33
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    output efm_pkg::fifo_wr_t wr,
    input  logic            fifo_full,
    output efm_pkg::seg_t   seg_out
);
    import efm_pkg::*;

    localparam logic [5:0] LAST_POS = 6'(BYTES_PER_FRAME - 1);

    logic [7:0] held_reg;
    logic [5:0] pos_reg;
    logic       s0_v_reg, s1_v_reg;
    seg_t       s0_reg, s1_reg;
    logic       accept, frame_end;

    assign in_ready  = !s0_v_reg && !s1_v_reg;
    assign accept    = in_valid && in_ready;
    assign frame_end = pos_reg >= LAST_POS;
    assign wr.push   = s0_v_reg && !fifo_full;
    assign wr.full   = fifo_full;
    assign seg_out   = s0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            pos_reg  <= '0;
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg <= in_byte;
            pos_reg  <= frame_end ? 6'd0 : pos_reg + 6'd1;
            s0_v_reg <= 1'b1;
            s1_v_reg <= frame_end;
        end
        else if (wr.push)
        begin
            s0_v_reg <= s1_v_reg;
            s1_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_reg.kind      <= (pos_reg == 6'd0) ? SEG_SYNC_WORD : SEG_WORD_WORD;
            s0_reg.word_a    <= EFM_TABLE[held_reg];
            s0_reg.word_b    <= EFM_TABLE[in_byte];
            s0_reg.first_seg <= 1'b1;
            s0_reg.last_seg  <= !frame_end;
            s0_reg.frame_end <= frame_end;
            s1_reg.kind      <= SEG_WORD_SYNC;
            s1_reg.word_a    <= EFM_TABLE[in_byte];
            s1_reg.word_b    <= '0;
            s1_reg.first_seg <= 1'b0;
            s1_reg.last_seg  <= 1'b1;
            s1_reg.frame_end <= frame_end;
        end
        else if (wr.push)
        begin
            s0_reg <= s1_reg;
        end
    end

endmodule

>>> rtl/efm_fifo.sv
// segment queue between front and back end
// depends on efm_pkg
module efm_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  efm_pkg::fifo_wr_t wr,
    input  efm_pkg::seg_t     wr_data,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output efm_pkg::seg_t     rd_data
);
    import efm_pkg::*;

    seg_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg;
    seg_t               rd_data_reg;
    logic               do_pop;

    assign full    = cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_pop  = pop && !empty;
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (FIFO_AW+1)'(wr.push) - (FIFO_AW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
            mem[wr_ptr_reg] <= wr_data;
        if (do_pop)
            rd_data_reg <= mem[rd_ptr_reg];
    end

endmodule

>>> rtl/efm_back.sv
// back end: merging choice, running sum, bit queue and run length output
// depends on efm_pkg and efm_channel_encoder_defines.svh
`include "efm_channel_encoder_defines.svh"
module efm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fifo_empty,
    output logic          pop,
    input  efm_pkg::seg_t seg,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [3:0]    out_run,
    output logic          out_last,
    output logic          out_frame,
    output logic          out_err
);
    import efm_pkg::*;

    function automatic logic window_ok(input logic [40:0] w, input logic chk_sync);
        logic bad;
        bad = ((w & (w >> 1)) != '0) || ((w & (w >> 2) & ~(w >> 1)) != '0);
        for (int i = 0; i < 31; i++)
        begin
            if (w[i +: 11] == '0 && (|(w << (41 - i))) && (|(w >> (i + 11))))
                bad = 1'b1;
        end
        if (chk_sync)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (w[i +: 24] == SYNC_PATTERN)
                    bad = 1'b1;
            end
        end
        return !bad;
    endfunction

    function automatic logic [15:0] sum_add(input logic [15:0] s, input logic [4:0] ones,
                                            input logic [5:0] len);
        logic [17:0] t;
        t = {{2{s[15]}}, s} + {12'b0, ones, 1'b0} - {12'b0, len};
        if (!t[17] && t[16:15] != 2'b00)
            return 16'h7fff;
        else if (t[17] && t[16:15] != 2'b11)
            return 16'h8000;
        else
            return t[15:0];
    endfunction

    bk_state_t           state_reg, state_next;
    logic [QUEUE_W-1:0]  q_reg, q_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic [15:0]         sum_reg, sum_next;
    logic [3:0]          ok_reg, ok_next;
    logic [2:0]          pat_reg, pat_next;
    logic                serr_reg, serr_next;
    logic                ov_reg, ov_next;
    logic [3:0]          orun_reg, orun_next;
    logic                olast_reg, olast_next;
    logic                oframe_reg, oframe_next;
    logic                oerr_reg, oerr_next;

    logic [40:0]         w0, w1, w2, w3;
    logic [23:0]         cur_bits;
    logic [11:0]         top12;
    logic [3:0]          zeros, take;
    logic [6:0]          newc;
    logic                none_ok, slot_free;

    always_comb
    begin
        case (seg.kind)
            SEG_SYNC_WORD:
            begin
                w0 = {SYNC_PATTERN, 3'b000, seg.word_b};
                w1 = {SYNC_PATTERN, 3'b001, seg.word_b};
                w2 = {SYNC_PATTERN, 3'b010, seg.word_b};
                w3 = {SYNC_PATTERN, 3'b100, seg.word_b};
            end
            SEG_WORD_SYNC:
            begin
                w0 = {seg.word_a, 3'b000, SYNC_PATTERN};
                w1 = {seg.word_a, 3'b001, SYNC_PATTERN};
                w2 = {seg.word_a, 3'b010, SYNC_PATTERN};
                w3 = {seg.word_a, 3'b100, SYNC_PATTERN};
            end
            default:
            begin
                w0 = {10'b0, seg.word_a, 3'b000, seg.word_b};
                w1 = {10'b0, seg.word_a, 3'b001, seg.word_b};
                w2 = {10'b0, seg.word_a, 3'b010, seg.word_b};
                w3 = {10'b0, seg.word_a, 3'b100, seg.word_b};
            end
        endcase
    end

    assign cur_bits  = (seg.kind == SEG_SYNC_WORD) ? SYNC_PATTERN : {10'b0, seg.word_a};
    assign top12     = 12'(q_reg >> (cnt_reg - RUN_WINDOW));
    assign none_ok   = ok_reg == 4'b0000;
    assign slot_free = !ov_reg || out_ready;

    always_comb
    begin
        zeros = 4'd11;
        for (int i = 0; i < 11; i++)
        begin
            if (top12[i])
                zeros = 4'(10 - i);
        end
    end

    assign take = (zeros < 4'd2) ? 4'd3 : zeros + 4'd1;
    assign newc = cnt_reg - {3'b0, take};

    always_comb
    begin
        state_next  = state_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        ok_next     = ok_reg;
        pat_next    = pat_reg;
        serr_next   = serr_reg;
        ov_next     = ov_reg && !out_ready;
        orun_next   = orun_reg;
        olast_next  = olast_reg;
        oframe_next = oframe_reg;
        oerr_next   = oerr_reg;
        pop         = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                ok_next = {window_ok(w3, seg.kind == SEG_WORD_WORD),
                           window_ok(w2, seg.kind == SEG_WORD_WORD),
                           window_ok(w1, seg.kind == SEG_WORD_WORD),
                           window_ok(w0, seg.kind == SEG_WORD_WORD)};
                state_next = BK_WORD;
            end
            BK_WORD:
            begin
                if (sum_reg[15])
                begin
                    if (ok_reg[1])      pat_next = 3'b001;
                    else if (ok_reg[2]) pat_next = 3'b010;
                    else if (ok_reg[3]) pat_next = 3'b100;
                    else                pat_next = 3'b000;
                end
                else
                begin
                    if (ok_reg[0])      pat_next = 3'b000;
                    else if (ok_reg[1]) pat_next = 3'b001;
                    else if (ok_reg[2]) pat_next = 3'b010;
                    else if (ok_reg[3]) pat_next = 3'b100;
                    else                pat_next = 3'b000;
                end
                serr_next = seg.first_seg ? none_ok : (serr_reg || none_ok);
                if (seg.kind == SEG_SYNC_WORD)
                begin
                    q_next   = (q_reg << 24) | {40'b0, SYNC_PATTERN};
                    cnt_next = cnt_reg + 7'd24;
                    sum_next = sum_add(sum_reg, 5'($countones(cur_bits)), 6'd24);
                end
                else
                begin
                    q_next   = (q_reg << 14) | {50'b0, seg.word_a};
                    cnt_next = cnt_reg + 7'd14;
                    sum_next = sum_add(sum_reg, 5'($countones(cur_bits)), 6'd14);
                end
                state_next = BK_MERGE;
            end
            BK_MERGE:
            begin
                q_next     = (q_reg << 3) | {61'b0, pat_reg};
                cnt_next   = cnt_reg + 7'd3;
                sum_next   = sum_add(sum_reg, 5'($countones(pat_reg)), 6'd3);
                state_next = seg.last_seg ? BK_RUN : BK_IDLE;
            end
            BK_RUN:
            begin
                if (slot_free)
                begin
                    ov_next     = 1'b1;
                    orun_next   = take;
                    olast_next  = newc < RUN_WINDOW;
                    oframe_next = (newc < RUN_WINDOW) && seg.frame_end;
                    oerr_next   = !top12[11] || zeros < 4'd2 || zeros > 4'd10 || serr_reg;
                    cnt_next    = newc;
                    q_next      = q_reg & ((64'd1 << newc) - 64'd1);
                    if (newc < RUN_WINDOW)
                        state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            q_reg     <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            serr_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            q_reg     <= q_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            serr_reg  <= serr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= ok_next;
        pat_reg    <= pat_next;
        orun_reg   <= orun_next;
        olast_reg  <= olast_next;
        oframe_reg <= oframe_next;
        oerr_reg   <= oerr_next;
    end

    assign out_valid = ov_reg;
    assign out_run   = orun_reg;
    assign out_last  = olast_reg;
    assign out_frame = oframe_reg;
    assign out_err   = oerr_reg;

    `EFM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= 7'd45)
    `EFM_ASSERT_NOW(a_run_range, ov_reg, orun_reg >= 4'd3 && orun_reg <= 4'd12)
    `EFM_ASSERT_NOW(a_run_exit, state_reg == BK_RUN && state_next == BK_IDLE,
                    cnt_next < RUN_WINDOW)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the efm channel encoder: frame bytes in, run lengths out
// depends on efm_pkg (efm table, sync pattern), efm_if and efm_channel_encoder
module tb_top;
    import efm_pkg::*;

    localparam int FRAME_BYTES = 33;
    localparam int RANDOM_WORDS = 205;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD = 300;
    localparam logic [3:0] SYNC_FIRST_RUN = 4'd11;

    typedef struct packed {
        logic [3:0] run_length;
        logic       last_of_item;
        logic       frame_done;
        logic       coding_error;
    } run_word_t;

    typedef struct {
        logic [7:0] data_byte;
        logic       has_first;
        logic [3:0] first_run;
    } stim_row_t;

    logic clk;
    logic rst_n;
    efm_byte_if bytes ();
    efm_run_if runs ();

    efm_channel_encoder #(.BYTES_PER_FRAME(FRAME_BYTES)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (bytes),
        .run_out (runs)
    );

    run_word_t expected_runs[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 0;
    bit hold_req = 0;

    logic [7:0]  prev_byte;
    int          frame_pos;
    int          disparity;
    logic [63:0] chan_bits;
    int          chan_count;
    bit          merge_fail;

    stim_row_t directed[] = '{
        '{8'h00, 1'b1, SYNC_FIRST_RUN}, '{8'hff, 1'b0, 4'd0}, '{8'h00, 1'b0, 4'd0},
        '{8'h01, 1'b0, 4'd0}, '{8'h80, 1'b0, 4'd0}, '{8'h55, 1'b0, 4'd0},
        '{8'haa, 1'b0, 4'd0}, '{8'h7f, 1'b0, 4'd0}, '{8'hfe, 1'b0, 4'd0},
        '{8'h0f, 1'b0, 4'd0}, '{8'hf0, 1'b0, 4'd0}, '{8'h20, 1'b0, 4'd0},
        '{8'h30, 1'b0, 4'd0}, '{8'h0d, 1'b0, 4'd0}, '{8'h16, 1'b0, 4'd0},
        '{8'hc2, 1'b0, 4'd0}, '{8'hff, 1'b0, 4'd0}, '{8'hff, 1'b0, 4'd0},
        '{8'h00, 1'b0, 4'd0}, '{8'h00, 1'b0, 4'd0}, '{8'h92, 1'b0, 4'd0},
        '{8'h6d, 1'b0, 4'd0}, '{8'h44, 1'b0, 4'd0}, '{8'hbb, 1'b0, 4'd0}
    };

    function automatic bit merge_fits(logic [63:0] cur, int lc, logic [2:0] pat,
                                      logic [63:0] nxt, int ln, bit no_sync);
        logic [63:0] w;
        int len;
        int last_one;
        len = lc + 3 + ln;
        w = (cur << (3 + ln)) | (64'(pat) << ln) | nxt;
        last_one = -1;
        if ((w & (w >> 1)) != 0) return 0;
        if ((w & (w >> 2) & ~(w >> 1)) != 0) return 0;
        for (int i = 0; i < len; i++)
        begin
            if (w[i])
            begin
                if (last_one >= 0 && i - last_one - 1 > 10) return 0;
                last_one = i;
            end
        end
        if (no_sync)
        begin
            for (int i = 0; i + 24 <= len; i++)
            begin
                if (w[i +: 24] == SYNC_PATTERN) return 0;
            end
        end
        return 1;
    endfunction

    task automatic append_bits(logic [63:0] v, int len);
        int ones;
        ones = 0;
        for (int i = 0; i < len; i++) ones += v[i];
        disparity += 2 * ones - len;
        if (disparity > 32767) disparity = 32767;
        if (disparity < -32768) disparity = -32768;
        chan_bits = (chan_bits << len) | v;
        chan_count += len;
    endtask

    task automatic append_segment(logic [63:0] cur, int lc, logic [63:0] nxt, int ln,
                                  bit no_sync);
        logic [2:0] pats[4];
        bit ok[4];
        int pick;
        pats = '{3'b000, 3'b001, 3'b010, 3'b100};
        pick = -1;
        for (int k = 0; k < 4; k++) ok[k] = merge_fits(cur, lc, pats[k], nxt, ln, no_sync);
        if (disparity < 0)
        begin
            for (int k = 3; k >= 1; k--) if (ok[k]) pick = k;
            if (pick < 0 && ok[0]) pick = 0;
        end
        else if (ok[0])
            pick = 0;
        else
        begin
            for (int k = 3; k >= 1; k--) if (ok[k]) pick = k;
        end
        if (pick < 0)
        begin
            merge_fail = 1;
            pick = 0;
        end
        append_bits(cur, lc);
        append_bits(64'(pats[pick]), 3);
    endtask

    task automatic encode_byte(logic [7:0] b, output logic [3:0] first_run);
        bit frame_end;
        int n;
        int zeros;
        int take;
        run_word_t r;
        frame_end = frame_pos >= FRAME_BYTES - 1;
        merge_fail = 0;
        n = 0;
        first_run = 0;
        if (frame_pos == 0)
            append_segment(64'(SYNC_PATTERN), 24, 64'(EFM_TABLE[b]), 14, 0);
        else
            append_segment(64'(EFM_TABLE[prev_byte]), 14, 64'(EFM_TABLE[b]), 14, 1);
        if (frame_end)
            append_segment(64'(EFM_TABLE[b]), 14, 64'(SYNC_PATTERN), 24, 0);
        prev_byte = b;
        frame_pos = frame_end ? 0 : frame_pos + 1;
        while (chan_count >= 12 && n < 12)
        begin
            zeros = 0;
            for (int i = 1; i < 12; i++)
            begin
                if (chan_bits[chan_count - 1 - i]) break;
                zeros++;
            end
            take = (zeros + 1 < 3) ? 3 : zeros + 1;
            r.run_length = 4'(take);
            r.last_of_item = 0;
            r.frame_done = 0;
            r.coding_error = !chan_bits[chan_count - 1] || zeros < 2 || zeros > 10
                             || merge_fail;
            if (n == 0) first_run = r.run_length;
            chan_count -= take;
            chan_bits &= (64'd1 << chan_count) - 64'd1;
            expected_runs.push_back(r);
            n++;
        end
        if (n > 0)
        begin
            expected_runs[$].last_of_item = 1;
            expected_runs[$].frame_done = frame_end;
        end
    endtask

    task automatic send_byte(logic [7:0] b, bit has_first, logic [3:0] first_run);
        logic [3:0] got_first;
        bytes.valid <= 1'b1;
        bytes.data_byte <= b;
        do @(posedge clk); while (!bytes.ready);
        encode_byte(b, got_first);
        if (has_first && got_first !== first_run)
        begin
            $display("%0t first run of byte %h: expected %0d actual %0d",
                     $time, b, first_run, got_first);
            errors++;
        end
        @(negedge clk);
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        run_word_t exp_run;
        if (rst_n && runs.valid && runs.ready)
        begin
            if (expected_runs.size() == 0)
            begin
                $display("%0t unexpected run: actual %0d", $time, runs.run_length);
                errors++;
            end
            else
            begin
                exp_run = expected_runs.pop_front();
                if (runs.run_length !== exp_run.run_length
                    || runs.last_of_item !== exp_run.last_of_item
                    || runs.frame_done !== exp_run.frame_done
                    || runs.coding_error !== exp_run.coding_error)
                begin
                    $display("%0t run mismatch: expected %0d/%b/%b/%b actual %0d/%b/%b/%b",
                             $time, exp_run.run_length, exp_run.last_of_item,
                             exp_run.frame_done, exp_run.coding_error, runs.run_length,
                             runs.last_of_item, runs.frame_done, runs.coding_error);
                    errors++;
                end
            end
        end
    end

    // receiver side: random hold bursts plus one long hold
    initial
    begin
        int gap;
        runs.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                runs.ready <= 1'b0;
                for (int i = 0; i < LONG_HOLD; i++) @(negedge clk);
                runs.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 10);
                runs.ready <= 1'b0;
                repeat (gap) @(negedge clk);
                runs.ready <= 1'b1;
            end
            else
                runs.ready <= 1'b1;
        end
    end

    initial
    begin
        logic [7:0] b;
        bytes.valid = 1'b0;
        bytes.data_byte = 8'h00;
        rst_n = 1'b0;
        prev_byte = 0;
        frame_pos = 0;
        disparity = 0;
        chan_bits = 0;
        chan_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_byte(directed[i].data_byte, directed[i].has_first, directed[i].first_run);
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i > RANDOM_WORDS - 30) quiet = 1;
            if (i == 40 && expected_runs.size() != 0)
            begin
                bytes.valid <= 1'b0;
                while (expected_runs.size() != 0) @(negedge clk);
            end
            if (i == 90) hold_req = 1;
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                bytes.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            case ($urandom_range(0, 7))
                0: b = 8'h00;
                1: b = 8'hff;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, 1'b0, 4'd0);
        end
        bytes.valid <= 1'b0;
        while (expected_runs.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/efm_pkg.sv
rtl/efm_if.sv
rtl/efm_front.sv
rtl/efm_fifo.sv
rtl/efm_back.sv
rtl/efm_channel_encoder.sv
tb/tb_top.sv
